// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the score/position priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam int KEY_W   = 64;
  localparam int FIELD_W = 32;
  localparam int CNT_W   = 11;
  localparam int LIMIT_W = 11;

  // score sign flip and position inversion used to build the packed key
  localparam logic [FIELD_W-1:0] SCORE_FLIP = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] POS_MAX    = 32'hffff_ffff;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic                      cmd;
    logic signed [FIELD_W-1:0] entry_score;
    logic        [FIELD_W-1:0] entry_position;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] top_score;
    logic        [FIELD_W-1:0] top_position;
    logic        [CNT_W-1:0]   entry_count;
    logic                      is_empty;
    logic                      op_ignored;
  } out_item_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } cell_ctl_t;

  // key with higher score first, then smaller position, as unsigned order
  function automatic key_t make_key(logic [FIELD_W-1:0] score_bits,
                                    logic [FIELD_W-1:0] pos);
    make_key = {score_bits ^ SCORE_FLIP, POS_MAX - pos};
  endfunction

endpackage

// ----- src/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted register chain: holds a key, compares it against
// the broadcast key, and shifts right on insert or left on removal.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  key_t      left_key,
  input  logic      left_gt,
  input  key_t      right_key,
  output key_t      key,
  output logic      gt
);

  key_t key_r;
  key_t key_nxt;

  // new key beats this slot (an empty slot loses to anything)
  assign gt  = !occupied || (ctl.key > key_r);
  assign key = key_r;

  // insert shifts larger-side neighbor in, removal pulls the right neighbor
  always_comb begin
    key_nxt = key_r;
    priority if (ctl.push) begin
      priority if (left_gt) begin
        key_nxt = left_key;
      end else if (gt) begin
        key_nxt = ctl.key;
      end else begin
        key_nxt = key_r;
      end
    end else if (ctl.pop) begin
      key_nxt = right_key;
    end else begin
      key_nxt = key_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- src/score_position_priority_queue.sv -----
// ----------------------------------------------------------------------------
// score_position_priority_queue
// Bounded max-priority queue of (score, position) entries kept sorted in a
// chain of register cells; the head cell is always the top entry.
// ----------------------------------------------------------------------------
//
//   channel  ports                       handshake
//   -------  --------------------------  ---------------------------------
//   input    start, busy, in_item        taken when start && !busy
//   result   out_valid, out_item         one-cycle strobe, no back-pressure
//   config   cfg_valid, cfg_ready,       written when cfg_valid && cfg_ready
//            cfg_data
//
// One item is taken every cycle; busy is never raised. All cells compare the
// new key in parallel, so a push or pop updates every cell of the chain together.
// The result for an item is registered through pend_r and then out_valid_r, in order.
// Reset clears the count, the limit (to 1024) and the strobes; cell contents
// are left as they are and only slots below the count are ever looked at.
// The receiver cannot stall, so nothing ever waits on the result side.
// ----------------------------------------------------------------------------
module score_position_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  output logic               out_valid,
  output out_item_t          out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               pend_r;
  logic               pend_ign_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               accept;
  logic               full;
  logic               empty;
  logic               do_push;
  logic               do_pop;
  logic               ignored;
  logic [LW-1:0]      count_ext;
  logic [LW-1:0]      limit_ext;
  logic [CW+CNT_W-1:0] count_wide;
  cell_ctl_t          ctl;

  key_t               key_w [CAPACITY];
  logic               gt_w  [CAPACITY];
  logic               occ_w [CAPACITY];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // full when the count reaches the programmed limit or the chain length
  assign count_ext = LW'(count_r);
  assign limit_ext = LW'(limit_r);
  assign full      = (count_ext >= limit_ext) || (count_r >= CW'(CAPACITY));
  assign empty     = (count_r == '0);

  assign do_push = accept && (in_item.cmd == CMD_PUSH) && !full;
  assign do_pop  = accept && (in_item.cmd == CMD_POP) && !empty;
  assign ignored = (in_item.cmd == CMD_PUSH) ? full : empty;

  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;
  assign ctl.key  = make_key(in_item.entry_score, in_item.entry_position);

  // count update
  always_comb begin
    count_nxt = count_r;
    priority if (do_push) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // sorted chain, largest key at the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_key;
    logic left_gt;
    key_t right_key;

    assign occ_w[i] = (count_r > CW'(i));

    if (i == 0) begin : g_head
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_key = key_w[i-1];
      assign left_gt  = gt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = key_w[i];
    end else begin : g_inner
      assign right_key = key_w[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ_w[i]),
      .left_key  (left_key),
      .left_gt   (left_gt),
      .right_key (right_key),
      .key       (key_w[i]),
      .gt        (gt_w[i])
    );
  end

  assign count_wide = {{CNT_W{1'b0}}, count_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      count_r     <= count_nxt;
      pend_r      <= accept;
      out_valid_r <= pend_r;
    end
  end

  // result capture from the settled chain head
  always_ff @(posedge clk) begin
    pend_ign_r <= ignored;
    if (empty) begin
      out_item_r.top_score    <= '0;
      out_item_r.top_position <= '0;
    end else begin
      out_item_r.top_score    <= key_w[0][KEY_W-1:FIELD_W] ^ SCORE_FLIP;
      out_item_r.top_position <= POS_MAX - key_w[0][FIELD_W-1:0];
    end
    out_item_r.entry_count <= count_wide[CNT_W-1:0];
    out_item_r.is_empty    <= empty;
    out_item_r.op_ignored  <= pend_ign_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a dropped push leaves the count alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.cmd == CMD_PUSH) && full) |=> (count_r == $past(count_r)))
    else $error("dropped push changed the count");

  // an accepted pop on a non-empty queue removes exactly one entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.cmd == CMD_POP) && !empty) |=>
      (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not remove one entry");

  // count never runs past the chain length
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count beyond capacity");

  // head key is no smaller than the second key whenever a second entry is present
  assert property (@(posedge clk) disable iff (!rst_n)
    occ_w[CAPACITY > 1 ? 1 : 0] |-> (key_w[0] >= key_w[CAPACITY > 1 ? 1 : 0]))
    else $error("chain head is not the largest key");

  // a result strobe follows each taken item
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("missing result strobe");

endmodule
